FILE: rtl/core/tprr_pkg.sv
package tprr_pkg;

  // widths of the item fields and of the configuration register
  localparam int SampleW = 8;
  localparam int ThrW    = 5;

  // saturating count width and longest emitted run
  localparam int CountBits = 16;
  localparam int MaxRun    = 64;

  // derived widths
  localparam int SumW  = CountBits + 1;
  localparam int RunW  = $clog2(MaxRun + 1);

  // run queue between classification and level output
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);

  // period classification steps
  localparam int PeriodStep = 9;
  localparam int LongSpan   = 2 * PeriodStep;
  localparam int OnesBias   = 4;
  localparam int VlBase     = 3;

  // division by the period step as a multiply by its reciprocal
  localparam int DivShift = CountBits + 4;
  localparam int DivMulW  = DivShift - 2;
  localparam logic [DivMulW-1:0] DivMul =
    DivMulW'((longint'(1) << DivShift) / PeriodStep + 1);

  // reset values
  localparam logic [ThrW-1:0]      ThrReset    = ThrW'(23);
  localparam logic [SampleW-1:0]   PeakReset   = '0;
  localparam logic [SampleW-1:0]   TroughReset = '1;
  localparam logic [SampleW-1:0]   SliceReset  = SampleW'(1 << (SampleW - 1));
  localparam logic [CountBits-1:0] CountMax    = '1;

  typedef enum logic [1:0] {
    ClsShort,
    ClsMid,
    ClsLong,
    ClsVeryLong
  } cls_e;

  // one finished period, as handed from the front to classification
  typedef struct packed {
    logic [CountBits-1:0] high;
    logic [CountBits-1:0] low;
    logic [SumW-1:0]      sum;
    logic [ThrW-1:0]      thr;
  } period_t;

  // one run of levels: ones levels of 1, then zeros up to total
  typedef struct packed {
    logic [RunW-1:0] total;
    logic [RunW-1:0] ones;
  } run_t;

  // midpoint of two samples, rounded down
  function automatic logic [SampleW-1:0] mid_level(input logic [SampleW-1:0] a,
                                                   input logic [SampleW-1:0] b);
    logic [SampleW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SampleW:1];
  endfunction

endpackage

FILE: rtl/core/tape_period_level_regenerator_core.sv
// Tape period level regenerator: takes one 8-bit unsigned cassette sample per beat,
// slices the waveform at the midpoint of its tracked peak and trough, times each full
// period and sends out a run of regenerated levels (level 1 stands for byte 0xC0,
// level 0 for 0x40), with last_of_run_o marking the final level of each period.
// A sample is taken in every cycle; the input stalls only while a finished period
// waits behind a full classification stage and a full four-entry run queue. The
// output gives one level per cycle while out_stall_i is low, and a period's run of 2 to 64
// levels comes out without gaps; the first level of a run passes the finished-period slot,
// the classification stage, the run queue and the run sequencer on its way out. period_threshold
// is written through cfg_we_i/cfg_wdata_i, resets to 23 and should be changed only
// while no run is pending.
module tape_period_level_regenerator_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [tprr_pkg::SampleW-1:0] sample_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         level_o,
  output logic                         last_of_run_o,
  input  logic                         cfg_we_i,
  input  logic [tprr_pkg::ThrW-1:0]    cfg_wdata_i
);
  import tprr_pkg::*;

  logic [ThrW-1:0] thr_q;
  logic            a_valid;
  period_t         a_period;
  logic            a_ready;
  logic            q_push;
  run_t            q_run;
  logic            q_full;
  logic            q_empty;
  logic            q_pop;
  run_t            q_head;

  // period threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  tprr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_i   (sample_i),
    .thr_i      (thr_q),
    .a_ready_i  (a_ready),
    .a_valid_o  (a_valid),
    .a_period_o (a_period)
  );

  tprr_classify u_classify (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .a_valid_i  (a_valid),
    .a_period_i (a_period),
    .a_ready_o  (a_ready),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .run_o      (q_run)
  );

  tprr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_run),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_head)
  );

  tprr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_head_i      (q_head),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .level_o       (level_o),
    .last_of_run_o (last_of_run_o)
  );

  // every queued run has at least two levels and no more ones than levels
  a_run_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (q_run.total >= RunW'(2)) && (q_run.ones <= q_run.total))
    else $error("malformed run descriptor queued");

  // input back-pressure only when a finished period is blocked by a full queue
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> a_valid && q_full)
    else $error("input stalled without a blocked period");

  // a run is delivered without gaps once its first level is taken
  a_run_unbroken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_run_o |=> out_valid_o)
    else $error("gap inside a run of levels");

endmodule

FILE: rtl/core/tprr_front.sv
module tprr_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [tprr_pkg::SampleW-1:0] sample_i,
  input  logic [tprr_pkg::ThrW-1:0]    thr_i,
  input  logic                         a_ready_i,
  output logic                         a_valid_o,
  output tprr_pkg::period_t            a_period_o
);
  import tprr_pkg::*;

  logic [SampleW-1:0]   peak_q, peak_d;
  logic [SampleW-1:0]   trough_q, trough_d;
  logic                 rising_q, rising_d;
  logic [SampleW-1:0]   slice_q, slice_d;
  logic [SampleW-1:0]   prev_q, prev_d;
  logic                 low_half_q, low_half_d;
  logic [CountBits-1:0] high_cnt_q, high_cnt_d;
  logic [CountBits-1:0] low_cnt_q, low_cnt_d;
  logic                 a_vld_q, a_vld_d;
  period_t              a_per_q, a_per_d;
  logic                 accept;
  logic                 period_end;

  // a beat is taken unless the finished-period slot is blocked
  assign in_stall_o = a_vld_q && !a_ready_i;
  assign accept     = in_valid_i && !in_stall_o;

  // waveform tracking and half-period counting
  always_comb begin
    peak_d     = peak_q;
    trough_d   = trough_q;
    rising_d   = rising_q;
    slice_d    = slice_q;
    prev_d     = prev_q;
    low_half_d = low_half_q;
    high_cnt_d = high_cnt_q;
    low_cnt_d  = low_cnt_q;
    period_end = 1'b0;
    if (accept) begin
      prev_d = sample_i;
      if (!low_half_q) begin
        if (sample_i > peak_q) begin
          peak_d = sample_i;
        end
        if (sample_i < prev_q && rising_q) begin
          rising_d = 1'b0;
          slice_d  = mid_level(peak_d, trough_q);
          trough_d = TroughReset;
        end
        if (sample_i > slice_d) begin
          if (high_cnt_q != CountMax) begin
            high_cnt_d = high_cnt_q + 1'b1;
          end
        end else begin
          low_half_d = 1'b1;
        end
      end else begin
        if (sample_i < trough_q) begin
          trough_d = sample_i;
        end
        if (sample_i > prev_q && !rising_q) begin
          rising_d = 1'b1;
          slice_d  = mid_level(peak_q, trough_d);
          peak_d   = PeakReset;
        end
        if (sample_i < slice_d) begin
          if (low_cnt_q != CountMax) begin
            low_cnt_d = low_cnt_q + 1'b1;
          end
        end else begin
          period_end = 1'b1;
          high_cnt_d = '0;
          low_cnt_d  = '0;
          low_half_d = 1'b0;
        end
      end
    end
  end

  // finished-period slot
  always_comb begin
    a_per_d = a_per_q;
    if (period_end) begin
      a_vld_d     = 1'b1;
      a_per_d.high = high_cnt_q;
      a_per_d.low  = low_cnt_q;
      a_per_d.sum  = {1'b0, high_cnt_q} + {1'b0, low_cnt_q};
      a_per_d.thr  = thr_i;
    end else if (a_ready_i) begin
      a_vld_d = 1'b0;
    end else begin
      a_vld_d = a_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q     <= PeakReset;
      trough_q   <= TroughReset;
      rising_q   <= 1'b0;
      slice_q    <= SliceReset;
      prev_q     <= '0;
      low_half_q <= 1'b0;
      high_cnt_q <= '0;
      low_cnt_q  <= '0;
      a_vld_q    <= 1'b0;
    end else begin
      peak_q     <= peak_d;
      trough_q   <= trough_d;
      rising_q   <= rising_d;
      slice_q    <= slice_d;
      prev_q     <= prev_d;
      low_half_q <= low_half_d;
      high_cnt_q <= high_cnt_d;
      low_cnt_q  <= low_cnt_d;
      a_vld_q    <= a_vld_d;
    end
  end

  // period payload
  always_ff @(posedge clk_i) begin
    a_per_q <= a_per_d;
  end

  assign a_valid_o  = a_vld_q;
  assign a_period_o = a_per_q;

endmodule

FILE: rtl/core/tprr_classify.sv
module tprr_classify (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              a_valid_i,
  input  tprr_pkg::period_t a_period_i,
  output logic              a_ready_o,
  input  logic              q_full_i,
  output logic              push_o,
  output tprr_pkg::run_t    run_o
);
  import tprr_pkg::*;

  localparam int ProdW = SumW + DivMulW;
  localparam int WideW = SumW + 1;

  logic                b_vld_q;
  cls_e                b_cls_q, b_cls_d;
  logic                b_hl_q, b_hl_d;
  logic                b_hm_q, b_hm_d;
  logic                b_ht_q, b_ht_d;
  logic [SumW-1:0]     b_qf_q, b_qf_d;
  logic [SumW-1:0]     b_qo_q, b_qo_d;
  logic                b_ready;
  logic [SumW-1:0]     thr_ext;
  logic [SumW-1:0]     high_ext;
  logic [SumW-1:0]     diff;
  logic [SumW-1:0]     biased;
  logic [ProdW-1:0]    prod_f;
  logic [ProdW-1:0]    prod_o;
  logic [WideW-1:0]    full_w;
  logic [WideW-1:0]    ones_w;
  logic [WideW-1:0]    tot_w;
  logic [WideW-1:0]    tot_cap;
  logic [WideW-1:0]    ones_cap;

  assign b_ready   = !b_vld_q || !q_full_i;
  assign a_ready_o = b_ready;
  assign push_o    = b_vld_q && !q_full_i;

  // class, comparisons and the two divisions by the period step
  always_comb begin
    thr_ext  = SumW'(a_period_i.thr);
    high_ext = {1'b0, a_period_i.high};
    diff     = a_period_i.sum - thr_ext;
    biased   = high_ext + SumW'(OnesBias);
    prod_f   = ProdW'(diff) * ProdW'(DivMul);
    prod_o   = ProdW'(biased) * ProdW'(DivMul);
    b_qf_d   = SumW'(prod_f >> DivShift);
    b_qo_d   = SumW'(prod_o >> DivShift);
    b_hl_d   = a_period_i.high > a_period_i.low;
    b_hm_d   = (high_ext + SumW'(PeriodStep)) > thr_ext;
    b_ht_d   = high_ext > thr_ext;
    if (a_period_i.sum < thr_ext) begin
      b_cls_d = ClsShort;
    end else if (a_period_i.sum < thr_ext + SumW'(PeriodStep)) begin
      b_cls_d = ClsMid;
    end else if (a_period_i.sum < thr_ext + SumW'(LongSpan)) begin
      b_cls_d = ClsLong;
    end else begin
      b_cls_d = ClsVeryLong;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (b_ready) begin
      b_vld_q <= a_valid_i;
    end
  end

  // classified period payload
  always_ff @(posedge clk_i) begin
    if (b_ready) begin
      b_cls_q <= b_cls_d;
      b_hl_q  <= b_hl_d;
      b_hm_q  <= b_hm_d;
      b_ht_q  <= b_ht_d;
      b_qf_q  <= b_qf_d;
      b_qo_q  <= b_qo_d;
    end
  end

  // very long run: length and ones, capped
  always_comb begin
    full_w = WideW'(b_qf_q) + WideW'(VlBase);
    ones_w = WideW'(b_qo_q);
    if (ones_w == full_w) begin
      ones_w = ones_w - 1'b1;
    end
    tot_w    = (ones_w > full_w) ? ones_w : full_w;
    tot_cap  = (tot_w > WideW'(MaxRun)) ? WideW'(MaxRun) : tot_w;
    ones_cap = (ones_w > tot_cap) ? tot_cap : ones_w;
  end

  // run descriptor for the queue
  always_comb begin
    case (b_cls_q)
      ClsShort: begin
        run_o.total = RunW'(2);
        run_o.ones  = RunW'(1);
      end
      ClsMid: begin
        run_o.total = RunW'(3);
        run_o.ones  = RunW'(1) + RunW'(b_hl_q);
      end
      ClsLong: begin
        run_o.total = RunW'(4);
        run_o.ones  = RunW'(1) + RunW'(b_hm_q) + RunW'(b_ht_q);
      end
      default: begin
        run_o.total = RunW'(tot_cap);
        run_o.ones  = RunW'(ones_cap);
      end
    endcase
  end

endmodule

FILE: rtl/core/tprr_fifo.sv
module tprr_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tprr_pkg::run_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output tprr_pkg::run_t data_o
);
  import tprr_pkg::*;

  run_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW:0]   cnt_q;
  logic             do_push;
  logic             do_pop;

  assign full_o  = cnt_q == (QPtrW + 1)'(QueueDepth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/core/tprr_back.sv
module tprr_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  tprr_pkg::run_t q_head_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           level_o,
  output logic           last_of_run_o
);
  import tprr_pkg::*;

  logic            cur_vld_q, cur_vld_d;
  logic [RunW-1:0] idx_q, idx_d;
  logic [RunW-1:0] tot_q, tot_d;
  logic [RunW-1:0] ones_q, ones_d;
  logic            out_vld_q, out_vld_d;
  logic            out_lvl_q, out_lvl_d;
  logic            out_last_q, out_last_d;
  logic            slot_free;
  logic            emit;
  logic            is_last;
  logic            load;

  assign slot_free = !out_vld_q || !out_stall_i;
  assign emit      = slot_free && cur_vld_q;
  assign is_last   = idx_q == (tot_q - 1'b1);
  assign load      = !q_empty_i && (!cur_vld_q || (emit && is_last));
  assign q_pop_o   = load;

  // level sequencing within a run
  always_comb begin
    cur_vld_d  = cur_vld_q;
    idx_d      = idx_q;
    tot_d      = tot_q;
    ones_d     = ones_q;
    out_vld_d  = out_vld_q;
    out_lvl_d  = out_lvl_q;
    out_last_d = out_last_q;
    if (emit) begin
      out_vld_d  = 1'b1;
      out_lvl_d  = idx_q < ones_q;
      out_last_d = is_last;
      idx_d      = idx_q + 1'b1;
      if (is_last) begin
        cur_vld_d = 1'b0;
      end
    end else if (slot_free) begin
      out_vld_d = 1'b0;
    end
    if (load) begin
      cur_vld_d = 1'b1;
      idx_d     = '0;
      tot_d     = q_head_i.total;
      ones_d    = q_head_i.ones;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      cur_vld_q <= cur_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // run and output payload
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    tot_q      <= tot_d;
    ones_q     <= ones_d;
    out_lvl_q  <= out_lvl_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o   = out_vld_q;
  assign level_o       = out_lvl_q;
  assign last_of_run_o = out_last_q;

endmodule

FILE: sim/testbench.sv
module testbench;
  import tprr_pkg::*;

  // one level beat as seen on the output
  typedef struct packed {
    logic level;
    logic last;
  } level_beat_t;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [SampleW-1:0] sample_i    = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               level_o;
  logic               last_of_run_o;
  logic               cfg_we_i    = 1'b0;
  logic [ThrW-1:0]    cfg_wdata_i = '0;

  // samples waiting to be driven and levels still to arrive
  logic [SampleW-1:0] pending_samples[$];
  level_beat_t        expected_levels[$];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatch_count;

  // slicer and period counter mirror
  logic [ThrW-1:0]      period_thr;
  logic [SampleW-1:0]   peak_q;
  logic [SampleW-1:0]   trough_q;
  logic                 rising_q;
  logic [SampleW-1:0]   slice_q;
  logic [SampleW-1:0]   prev_q;
  logic                 in_low_half;
  logic [CountBits-1:0] high_cnt;
  logic [CountBits-1:0] low_cnt;

  tape_period_level_regenerator_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_i      (sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .level_o       (level_o),
    .last_of_run_o (last_of_run_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // classify the finished period and queue its run of levels
  function automatic void queue_period_run();
    int t;
    int h;
    int l;
    int s;
    int full;
    int ones;
    int total;
    int n;
    bit run_lv [MaxRun];
    t = int'(period_thr);
    h = int'(high_cnt);
    l = int'(low_cnt);
    s = h + l;
    if (s < t) begin
      run_lv[0] = 1'b1;
      run_lv[1] = 1'b0;
      n = 2;
    end else if (s < t + PeriodStep) begin
      run_lv[0] = 1'b1;
      run_lv[1] = (h > l);
      run_lv[2] = 1'b0;
      n = 3;
    end else if (s < t + LongSpan) begin
      run_lv[0] = 1'b1;
      // signed compare, the threshold may be below the step
      run_lv[1] = (h > t - PeriodStep);
      run_lv[2] = (h > t);
      run_lv[3] = 1'b0;
      n = 4;
    end else begin
      full = VlBase + (s - t) / PeriodStep;
      ones = (h + OnesBias) / PeriodStep;
      if (ones == full) ones = ones - 1;
      total = (ones > full) ? ones : full;
      if (total > MaxRun) total = MaxRun;
      if (ones > total) ones = total;
      for (int i = 0; i < total; i++) run_lv[i] = (i < ones);
      n = total;
    end
    for (int i = 0; i < n; i++)
      expected_levels.push_back(level_beat_t'{run_lv[i], (i == n - 1)});
  endfunction

  // advance the slicer by one accepted sample
  function automatic void slice_sample(input logic [SampleW-1:0] v);
    if (!in_low_half) begin
      if (v > peak_q) peak_q = v;
      if (v < prev_q && rising_q) begin
        rising_q = 1'b0;
        slice_q  = SampleW'((int'(peak_q) + int'(trough_q)) / 2);
        trough_q = '1;
      end
      prev_q = v;
      if (v > slice_q) begin
        if (high_cnt != CountMax) high_cnt = high_cnt + 1'b1;
      end else begin
        in_low_half = 1'b1;
      end
    end else begin
      if (v < trough_q) trough_q = v;
      if (v > prev_q && !rising_q) begin
        rising_q = 1'b1;
        slice_q  = SampleW'((int'(peak_q) + int'(trough_q)) / 2);
        peak_q   = '0;
      end
      prev_q = v;
      if (v < slice_q) begin
        if (low_cnt != CountMax) low_cnt = low_cnt + 1'b1;
      end else begin
        queue_period_run();
        high_cnt    = '0;
        low_cnt     = '0;
        in_low_half = 1'b0;
      end
    end
  endfunction

  // sample driver, also tracks the threshold register
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      period_thr  = ThrReset;
      peak_q      = PeakReset;
      trough_q    = TroughReset;
      rising_q    = 1'b0;
      slice_q     = SliceReset;
      prev_q      = '0;
      in_low_half = 1'b0;
      high_cnt    = '0;
      low_cnt     = '0;
    end else begin
      if (cfg_we_i) period_thr = cfg_wdata_i;
      if (in_valid_i && !in_stall_o) slice_sample(sample_i);
      if (in_valid_i && in_stall_o) begin
        // hold the stalled beat
      end else if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        sample_i   <= pending_samples.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // level monitor and random output stall
  always @(posedge clk_i or negedge rst_ni) begin
    level_beat_t exp_beat;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_levels.size() == 0) begin
          $error("level beat with nothing expected: level %0d last %0d",
                 level_o, last_of_run_o);
          mismatch_count++;
        end else begin
          exp_beat = expected_levels.pop_front();
          if (level_o !== exp_beat.level) begin
            $error("level: expected %0d, got %0d", exp_beat.level, level_o);
            mismatch_count++;
          end
          if (last_of_run_o !== exp_beat.last) begin
            $error("last_of_run: expected %0d, got %0d", exp_beat.last, last_of_run_o);
            mismatch_count++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // one period: high half, sample ending it, low half, sample ending the period
  task automatic add_period(input int n_high, input int n_low, input bit steady);
    for (int i = 0; i < n_high; i++)
      pending_samples.push_back(steady ? 8'd240 : SampleW'($urandom_range(255, 172)));
    for (int i = 0; i <= n_low; i++)
      pending_samples.push_back(steady ? 8'd20 : SampleW'($urandom_range(83, 0)));
    pending_samples.push_back(SampleW'($urandom_range(255, 172)));
  endtask

  // wait for everything queued to come out, plus the pipeline latency
  task automatic settle();
    while (pending_samples.size() != 0 || in_valid_i || expected_levels.size() != 0)
      @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [ThrW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // stimulus sequence
  initial begin
    int chunk_start;
    int pick;
    logic [ThrW-1:0] thr_pick [3];
    mismatch_count = 0;
    send_idle_pct  = 23;
    recv_idle_pct  = 56;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sample equal to the reset slice ends the first high half at once
    pending_samples.push_back(8'd128);
    pending_samples.push_back(8'd0);
    pending_samples.push_back(8'd255);
    // short period at the reset threshold
    add_period(3, 2, 1'b0);
    settle();

    // zero threshold: nothing is short, and threshold minus step goes negative
    write_threshold(5'd0);
    add_period(0, 0, 1'b0);
    add_period(4, 1, 1'b0);
    add_period(3, 8, 1'b0);
    add_period(12, 10, 1'b0);
    settle();

    // ones exceeding full
    write_threshold(5'd27);
    add_period(50, 0, 1'b1);
    settle();

    // random periods with bursts of noise, three idling regimes
    thr_pick = '{5'd18, 5'd23, 5'($urandom_range(31))};
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 23 : (p == 1) ? 56 : 0;
      recv_idle_pct = (p == 0) ? 56 : (p == 1) ? 23 : 0;
      write_threshold(thr_pick[p]);
      chunk_start = pending_samples.size();
      while (pending_samples.size() - chunk_start < 16) begin
        pick = $urandom_range(9);
        if (pick == 0) begin
          repeat ($urandom_range(6, 1))
            pending_samples.push_back(SampleW'($urandom_range(255)));
        end else begin
          add_period($urandom_range(12), $urandom_range(12), 1'b0);
        end
      end
      settle();
    end

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run time limit
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
